// ===== src/smcn_pkg.sv =====
// Shared constants, types and helpers of the sensor min/max calibrator and normalizer.
`timescale 1ns / 1ps

package smcn_pkg;

    // Converter resolution and number of tracked channels.
    localparam int ADC_BITS    = 12;
    localparam int CHANNELS    = 5;

    // Fixed field layout of the stream words.
    localparam int FIELD_LANES = 5;
    localparam int SAMPLE_W    = 12;
    localparam int LEVEL_W     = 16;
    localparam int CFG_W       = 6;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 88;

    // Lanes that carry a calibrated channel.
    localparam int LANES = (CHANNELS < FIELD_LANES) ? CHANNELS : FIELD_LANES;

    // Percent scaling: the scaled numerator needs seven more bits than a sample.
    localparam int PERCENT = 100;
    localparam int NUM_W   = ADC_BITS + 7;
    localparam int CNT_W   = $clog2(NUM_W);

    localparam logic [CFG_W-1:0] WARMUP_RESET = CFG_W'(21);
    localparam logic [CFG_W-1:0] COUNT_MAX    = CFG_W'(63);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'h7FFF;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 16'h8000;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Item kinds, as carried in tuser.
    localparam logic ITEM_CAL  = 1'b0;
    localparam logic ITEM_READ = 1'b1;

    typedef logic [ADC_BITS-1:0] adc_t;

    typedef struct packed {
        logic                   kind;
        adc_t [FIELD_LANES-1:0] sample;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    // Fits a 12-bit field to the converter width (truncate or zero-extend).
    function automatic adc_t mask_sample(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W+ADC_BITS-1:0] ext;
        ext = (SAMPLE_W + ADC_BITS)'(raw);
        return ext[ADC_BITS-1:0];
    endfunction

endpackage

// ===== src/sensor_minmax_calibrate_normalize.sv =====
// Top level of the five-channel light sensor min/max calibrator and normalizer.
`timescale 1ns / 1ps

// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         tdata: five 12-bit samples, outer left to outer right; tuser: func
// m_axis    out        tdata: five 16-bit signed levels, then the 5-bit span error mask
// cfg       in         cfg_wdata: warmup_samples, written when cfg_we is high
//
// A calibration word leaves the queue and, once warm-up is over, updates min/max.
// A read word is handled in the back end in order: the lane dividers are loaded,
// the restoring dividers produce one quotient bit per step, and the result register
// is written. The back end takes no new word until that result register is written.
// Reset is synchronous and active low; it restores min 4095, max 0, count 0, warm-up 21.
// A two-word queue parts the input side from the back end, and the result register
// lets calibration words keep flowing while a result waits for m_axis_tready.

module sensor_minmax_calibrate_normalize import smcn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: warmup_samples.
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // Input words.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample_outer_left, sample_left,
                                                  // sample_center, sample_right,
                                                  // sample_outer_right, zero pad
    input  logic                  s_axis_tuser,   // func
    // Result words.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // level_outer_left, level_left,
                                                  // level_center, level_right,
                                                  // level_outer_right, span_error_mask,
                                                  // zero pad
);

    qhead_t head;
    logic   pop;

    // The front end classifies each word and holds it until the back end is free.
    smcn_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .pop           (pop),
        .head          (head)
    );

    // The back end tracks the span per channel and normalizes read words.
    smcn_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== src/smcn_front.sv =====
// Front end: accepts input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module smcn_front import smcn_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 pop,
    output qhead_t               head
);

    item_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0]   fill_reg, fill_next;
    item_t                in_item;
    logic                 push;
    logic                 do_pop;

    always_comb begin
        in_item.kind = (s_axis_tuser == ITEM_READ) ? ITEM_READ : ITEM_CAL;
        for (int c = 0; c < FIELD_LANES; c++) begin
            in_item.sample[c] = mask_sample(s_axis_tdata[c*SAMPLE_W +: SAMPLE_W]);
        end
    end

    assign s_axis_tready = (fill_reg != QFILL_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign do_pop        = pop && (fill_reg != '0);

    assign head.valid = (fill_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push   ? QPTR_W'((int'(wr_ptr_reg) + 1) % QUEUE_DEPTH) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'((int'(rd_ptr_reg) + 1) % QUEUE_DEPTH) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!push && do_pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== src/smcn_div.sv =====
// One lane of restoring division, one quotient bit per step.
`timescale 1ns / 1ps

module smcn_div import smcn_pkg::*; (
    input  logic             aclk,
    input  logic             load,
    input  logic             step,
    input  logic [NUM_W-1:0] num,
    input  adc_t             den,
    output logic [NUM_W-1:0] quo
);

    adc_t              rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    adc_t              den_reg;
    logic [ADC_BITS:0] trial;
    logic [ADC_BITS:0] diff;

    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (trial >= {1'b0, den_reg}) begin
            rem_next = diff[ADC_BITS-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b1};
        end else begin
            rem_next = trial[ADC_BITS-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// ===== src/smcn_back.sv =====
// Back end: min/max tracking, per-lane division sequencer and the result register.
`timescale 1ns / 1ps

module smcn_back import smcn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  qhead_t                head,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0] warmup_reg;
    logic [CFG_W-1:0] count_reg;
    adc_t             min_reg [LANES];
    adc_t             max_reg [LANES];
    logic             neg_reg [LANES];
    logic             zero_reg [LANES];
    logic             out_valid_reg, out_valid_next;

    logic [FIELD_LANES-1:0][LEVEL_W-1:0] out_level_reg;
    logic [FIELD_LANES-1:0]              out_err_reg;
    logic [FIELD_LANES-1:0][LEVEL_W-1:0] lane_level;
    logic [FIELD_LANES-1:0]              lane_err;

    logic take_cal;
    logic take_read;
    logic div_step;
    logic out_write;

    assign take_cal  = (state_reg == ST_IDLE) && head.valid && (head.item.kind == ITEM_CAL);
    assign take_read = (state_reg == ST_IDLE) && head.valid && (head.item.kind == ITEM_READ);
    assign pop       = take_cal || take_read;
    assign div_step  = (state_reg == ST_DIV);
    assign out_write = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take_read) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_write) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_write) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            warmup_reg    <= WARMUP_RESET;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                warmup_reg <= cfg_wdata;
            end
            if (take_cal && (count_reg != COUNT_MAX)) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    for (genvar c = 0; c < FIELD_LANES; c++) begin : g_lane
        if (c < LANES) begin : g_used
            logic [ADC_BITS:0] diff_num;
            logic [ADC_BITS:0] diff_den;
            logic [ADC_BITS:0] abs_num;
            logic [ADC_BITS:0] abs_den;
            logic [NUM_W-1:0]  num;
            logic [NUM_W-1:0]  quo;
            logic [31:0]       quo_x;
            adc_t              smp;

            assign smp      = head.item.sample[c];
            assign diff_num = {1'b0, smp} - {1'b0, min_reg[c]};
            assign diff_den = {1'b0, max_reg[c]} - {1'b0, min_reg[c]};
            assign abs_num  = diff_num[ADC_BITS] ? -diff_num : diff_num;
            assign abs_den  = diff_den[ADC_BITS] ? -diff_den : diff_den;
            assign num      = NUM_W'(abs_num[ADC_BITS-1:0]) * NUM_W'(PERCENT);

            smcn_div u_div (
                .aclk (aclk),
                .load (take_read),
                .step (div_step),
                .num  (num),
                .den  (abs_den[ADC_BITS-1:0]),
                .quo  (quo)
            );

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    min_reg[c] <= '1;
                    max_reg[c] <= '0;
                end else if (take_cal && (count_reg >= warmup_reg)) begin
                    if (smp > max_reg[c]) begin
                        max_reg[c] <= smp;
                    end
                    if (smp < min_reg[c]) begin
                        min_reg[c] <= smp;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (take_read) begin
                    neg_reg[c]  <= diff_num[ADC_BITS] ^ diff_den[ADC_BITS];
                    zero_reg[c] <= (diff_den == '0);
                end
            end

            // Truncating division of magnitudes, then the sign, then clamp to int16.
            assign quo_x = 32'(quo);
            always_comb begin
                lane_err[c] = 1'b0;
                if (zero_reg[c]) begin
                    lane_level[c] = '0;
                    lane_err[c]   = 1'b1;
                end else if (neg_reg[c]) begin
                    lane_level[c] = (quo_x > 32'd32768) ? LEVEL_MIN : -LEVEL_W'(quo);
                end else begin
                    lane_level[c] = (quo_x > 32'd32767) ? LEVEL_MAX : LEVEL_W'(quo);
                end
            end
        end else begin : g_unused
            assign lane_level[c] = '0;
            assign lane_err[c]   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_write) begin
            out_level_reg <= lane_level;
            out_err_reg   <= lane_err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_err_reg, out_level_reg});

endmodule

// ===== src/smcn_checker.sv =====
// Port-level checker of the calibrator and normalizer, bound to the top level.
`timescale 1ns / 1ps

module smcn_checker import smcn_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int ERR_LSB = FIELD_LANES * LEVEL_W;

    // No result can be pending in the cycle after reset.
    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // A stalled result word keeps its contents.
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // A channel flagged with a zero span reports level zero.
    for (genvar c = 0; c < FIELD_LANES; c++) begin : g_err
        a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
            m_axis_tvalid && m_axis_tdata[ERR_LSB + c] |->
                (m_axis_tdata[c*LEVEL_W +: LEVEL_W] == '0))
            else $error("span error set with nonzero level");
    end

    // Padding bits above the error mask stay clear.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:ERR_LSB+FIELD_LANES] == '0))
        else $error("result padding not zero");

endmodule

bind sensor_minmax_calibrate_normalize smcn_checker u_smcn_checker (.*);
